// File: hw/rtl/mrgc_pkg.sv
// Shared types and constants for the Manhattan radial gradient color block.
// No dependencies.
package mrgc_pkg;

	// Coordinate width of pixels and center
	localparam int COORD_BITS  = 12;
	localparam int RADIUS_BITS = 13;
	localparam int COLOR_BITS  = 24;
	localparam int CHAN_BITS   = 8;
	localparam int NUM_CHANS   = 3;

	// Sum of two coordinate differences, and a width that also holds the radius
	localparam int DIST_BITS = COORD_BITS + 1;
	localparam int CMP_BITS  = (DIST_BITS > RADIUS_BITS) ? DIST_BITS : RADIUS_BITS;

	// d * c with d < r: quotient by r always fits one channel
	localparam int PROD_BITS = RADIUS_BITS + CHAN_BITS;
	localparam int QUOT_BITS = CHAN_BITS;

	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = COLOR_BITS;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_START_COLOR = 3'd0,
		REG_END_COLOR   = 3'd1,
		REG_FADE_RADIUS = 3'd2,
		REG_CENTER_X    = 3'd3,
		REG_CENTER_Y    = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] pixel_x;
		logic [COORD_BITS-1:0] pixel_y;
	} pix_req_t;

	typedef struct packed {
		logic [CHAN_BITS-1:0] out_red;
		logic [CHAN_BITS-1:0] out_green;
		logic [CHAN_BITS-1:0] out_blue;
	} color_req_t;

	// Channel k of a packed color: 0 red, 1 green, 2 blue
	function automatic logic [CHAN_BITS-1:0] chan(input logic [COLOR_BITS-1:0] word,
		input int k);
		logic [COLOR_BITS-1:0] sh;
		sh = word >> (CHAN_BITS * (NUM_CHANS - 1 - k));
		return sh[CHAN_BITS-1:0];
	endfunction

endpackage

// File: hw/rtl/mrgc_dist.sv
// Two-stage Manhattan distance and radius compare.
// Depends on mrgc_pkg.
module mrgc_dist (
	input  logic                        clk,
	input  logic                        en,
	input  mrgc_pkg::pix_req_t          pix,
	input  logic [mrgc_pkg::COORD_BITS-1:0]  center_x,
	input  logic [mrgc_pkg::COORD_BITS-1:0]  center_y,
	input  logic [mrgc_pkg::RADIUS_BITS-1:0] radius,
	output logic [mrgc_pkg::CMP_BITS-1:0]    dsum,
	output logic                        far
);
	import mrgc_pkg::*;

	logic [COORD_BITS-1:0] dx_s1, dy_s1;
	logic [CMP_BITS-1:0]   d_s2;
	logic                  far_s2;
	logic [CMP_BITS-1:0]   d_sum;

	// s1: absolute differences
	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= (center_x >= pix.pixel_x) ? center_x - pix.pixel_x
				: pix.pixel_x - center_x;
			dy_s1 <= (center_y >= pix.pixel_y) ? center_y - pix.pixel_y
				: pix.pixel_y - center_y;
		end
	end

	assign d_sum = CMP_BITS'(dx_s1) + CMP_BITS'(dy_s1);

	// s2: sum and compare against the radius
	always_ff @(posedge clk) begin
		if (en) begin
			d_s2   <= d_sum;
			far_s2 <= (d_sum >= CMP_BITS'(radius));
		end
	end

	assign dsum = d_s2;
	assign far  = far_s2;

endmodule

// File: hw/rtl/mrgc_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Assumes num < den << QUOT_BITS. Depends on mrgc_pkg.
module mrgc_div (
	input  logic                             clk,
	input  logic                             en,
	input  logic [mrgc_pkg::PROD_BITS-1:0]   num,
	input  logic [mrgc_pkg::RADIUS_BITS-1:0] den,
	output logic [mrgc_pkg::QUOT_BITS-1:0]   quot
);
	import mrgc_pkg::*;

	logic [PROD_BITS-1:0] rem_s [QUOT_BITS];
	logic [QUOT_BITS-1:0] quo_s [QUOT_BITS];

	for (genvar i = 0; i < QUOT_BITS; i++) begin : g_stage
		localparam int BIT = QUOT_BITS - 1 - i;
		logic [PROD_BITS-1:0] rem_in, den_sh;
		logic [QUOT_BITS-1:0] quo_in;
		logic                 ge;

		if (i == 0) begin : g_first
			assign rem_in = num;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[i-1];
			assign quo_in = quo_s[i-1];
		end

		assign den_sh = PROD_BITS'(den) << BIT;
		assign ge     = (rem_in >= den_sh);

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= ge ? rem_in - den_sh : rem_in;
				quo_s[i] <= quo_in | (QUOT_BITS'(ge) << BIT);
			end
		end
	end

	assign quot = quo_s[QUOT_BITS-1];

endmodule

// File: hw/rtl/manhattan_radial_gradient_color.sv
// Manhattan radial gradient color generator, top level.
// Depends on mrgc_pkg, mrgc_dist, mrgc_div.
//
// One pixel coordinate per request goes in, one RGB color per request comes out, in
// order. Each channel is start - floor(d*start/r) + floor(d*end/r), where d is the
// Manhattan distance to the center and r the fade radius; at d >= r (so always when
// r is zero) the end color is returned unchanged. Throughput is one request per
// clock while no result is held by out_stall. A request passes through the distance
// and radius compare, the six d*color products, the divider pipeline (one quotient
// bit per stage) and the final blend into the output register. The whole pipeline
// moves as one: when a finished result is held by out_stall, every stage freezes and
// in_stall rises in the same cycle, so nothing is dropped or repeated. The user must
// write registers through cfg_wen/cfg_index/cfg_wdata only while no request is in
// flight (not enforced); unknown indexes are ignored and all registers reset to zero.
module manhattan_radial_gradient_color (
	input  logic                               clk,
	input  logic                               arst_n,

	input  logic                               cfg_wen,
	input  logic [mrgc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [mrgc_pkg::CFG_DATA_BITS-1:0] cfg_wdata,

	input  logic                               in_valid,
	output logic                               in_stall,
	input  mrgc_pkg::pix_req_t                 in_req,

	output logic                               out_valid,
	input  logic                               out_stall,
	output mrgc_pkg::color_req_t               out_req
);
	import mrgc_pkg::*;

	// stages: dist (2), product (1), divider (QUOT_BITS), blend (1)
	localparam int DEPTH = 3 + QUOT_BITS + 1;

	// configuration
	logic [COLOR_BITS-1:0]  start_color_q, end_color_q;
	logic [RADIUS_BITS-1:0] fade_radius_q;
	logic [COORD_BITS-1:0]  center_x_q, center_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_color_q <= '0;
			end_color_q   <= '0;
			fade_radius_q <= '0;
			center_x_q    <= '0;
			center_y_q    <= '0;
		end else if (cfg_wen) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_START_COLOR: start_color_q <= cfg_wdata[COLOR_BITS-1:0];
				REG_END_COLOR:   end_color_q   <= cfg_wdata[COLOR_BITS-1:0];
				REG_FADE_RADIUS: fade_radius_q <= cfg_wdata[RADIUS_BITS-1:0];
				REG_CENTER_X:    center_x_q    <= cfg_wdata[COORD_BITS-1:0];
				REG_CENTER_Y:    center_y_q    <= cfg_wdata[COORD_BITS-1:0];
				default: ;
			endcase
		end
	end

	// global advance: only a held result at the output stops the pipe
	logic en;
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	// valid bits, one per stage
	logic [DEPTH-1:0] vld_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[DEPTH-2:0], in_valid};
		end
	end

	// s1..s2: distance
	logic [CMP_BITS-1:0] dist_s2;
	logic                far_s2;

	mrgc_dist u_dist (
		.clk      (clk),
		.en       (en),
		.pix      (in_req),
		.center_x (center_x_q),
		.center_y (center_y_q),
		.radius   (fade_radius_q),
		.dsum     (dist_s2),
		.far      (far_s2)
	);

	// s3: products; near pixels have d < r, so the low radius bits hold d
	logic [PROD_BITS-1:0] p_start_s3 [NUM_CHANS];
	logic [PROD_BITS-1:0] p_end_s3   [NUM_CHANS];
	logic                 far_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			far_s3 <= far_s2;
			for (int k = 0; k < NUM_CHANS; k++) begin
				p_start_s3[k] <= PROD_BITS'(dist_s2[RADIUS_BITS-1:0])
					* PROD_BITS'(chan(start_color_q, k));
				p_end_s3[k]   <= PROD_BITS'(dist_s2[RADIUS_BITS-1:0])
					* PROD_BITS'(chan(end_color_q, k));
			end
		end
	end

	// s4..s11: dividers, far flag rides alongside
	logic [QUOT_BITS-1:0] q_start [NUM_CHANS];
	logic [QUOT_BITS-1:0] q_end   [NUM_CHANS];
	logic [QUOT_BITS-1:0] far_d_q;

	for (genvar k = 0; k < NUM_CHANS; k++) begin : g_chan
		mrgc_div u_div_start (
			.clk  (clk),
			.en   (en),
			.num  (p_start_s3[k]),
			.den  (fade_radius_q),
			.quot (q_start[k])
		);
		mrgc_div u_div_end (
			.clk  (clk),
			.en   (en),
			.num  (p_end_s3[k]),
			.den  (fade_radius_q),
			.quot (q_end[k])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			far_d_q <= {far_d_q[QUOT_BITS-2:0], far_s3};
		end
	end

	// s12: blend and output register
	logic [CHAN_BITS-1:0] mix [NUM_CHANS];
	color_req_t           res_s12;

	always_comb begin
		for (int k = 0; k < NUM_CHANS; k++) begin
			if (far_d_q[QUOT_BITS-1]) begin
				mix[k] = chan(end_color_q, k);
			end else begin
				mix[k] = chan(start_color_q, k) - q_start[k] + q_end[k];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s12.out_red   <= mix[0];
			res_s12.out_green <= mix[1];
			res_s12.out_blue  <= mix[2];
		end
	end

	assign out_valid = vld_s[DEPTH-1];
	assign out_req   = res_s12;

endmodule

// File: tb/manhattan_radial_gradient_color_tb.sv
// Self-checking testbench for manhattan_radial_gradient_color: directed and random pixel
// requests under random valid gaps and output stalls, checked against a local predictor.
// Depends on mrgc_pkg and the manhattan_radial_gradient_color RTL.
module manhattan_radial_gradient_color_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mrgc_pkg::*;

	// Pipeline depth, as DEPTH in the block; used for settle time only
	localparam int PIPE_LATENCY    = 12;
	localparam int RESET_CYCLES    = 12;
	localparam int CYCLE_LIMIT     = 200000;
	localparam int RANDOM_PHASES   = 10;
	localparam int PIXELS_PER_PHASE = 70;
	localparam int MAX_REPORTS     = 40;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic                     cfg_wen = 1'b0;
	logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

	logic       in_valid = 1'b0;
	logic       in_stall;
	pix_req_t   in_req = '0;

	logic       out_valid;
	logic       out_stall = 1'b0;
	color_req_t out_req;

	// Local copy of the block's registers, updated as each write lands
	logic [COLOR_BITS-1:0]  start_color_reg = '0;
	logic [COLOR_BITS-1:0]  end_color_reg = '0;
	logic [RADIUS_BITS-1:0] fade_radius_reg = '0;
	logic [COORD_BITS-1:0]  center_x_reg = '0;
	logic [COORD_BITS-1:0]  center_y_reg = '0;

	pix_req_t   pixel_queue[$];      // requests waiting to be sent
	color_req_t expected_colors[$];  // colors owed by the block, oldest first

	int pushed_count = 0;
	int accepted_count = 0;
	int fail_count = 0;
	int cycle_count = 0;
	bit no_idle = 1'b0;              // set for whole phases to run back to back

	manhattan_radial_gradient_color DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_req    (in_req),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_req   (out_req)
	);

	always #2 clk = ~clk;

	// Hard stop in case the block hangs
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int roll;
		if (no_idle)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 75)
			return 0;
		if (roll < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Color for one pixel under the current register copy.
	// Distance is exact at coordinate width; at or past the radius the end color
	// is returned as is, which also covers a zero radius (no divide then).
	function automatic color_req_t predict_color(pix_req_t pix);
		int unsigned dx, dy, dist_sum, radius, c_start, c_end, mixed;
		logic [CHAN_BITS-1:0] chans[NUM_CHANS];
		color_req_t res;
		dx = (pix.pixel_x >= center_x_reg) ? pix.pixel_x - center_x_reg
			: center_x_reg - pix.pixel_x;
		dy = (pix.pixel_y >= center_y_reg) ? pix.pixel_y - center_y_reg
			: center_y_reg - pix.pixel_y;
		dist_sum = dx + dy;
		radius = fade_radius_reg;
		for (int k = 0; k < NUM_CHANS; k++) begin
			c_start = (start_color_reg >> (CHAN_BITS * (NUM_CHANS - 1 - k))) & 8'hFF;
			c_end = (end_color_reg >> (CHAN_BITS * (NUM_CHANS - 1 - k))) & 8'hFF;
			if (dist_sum >= radius) begin
				chans[k] = c_end[CHAN_BITS-1:0];
			end else begin
				// fade: start - floor(d*start/r) + floor(d*end/r), truncating divides
				mixed = c_start - (dist_sum * c_start) / radius
					+ (dist_sum * c_end) / radius;
				chans[k] = mixed[CHAN_BITS-1:0];
			end
		end
		res.out_red = chans[0];
		res.out_green = chans[1];
		res.out_blue = chans[2];
		return res;
	endfunction

	// Request driver: holds the payload while stalled, random idle gaps between requests
	always @(posedge clk) begin : pixel_driver
		int send_gap;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				expected_colors.push_back(predict_color(in_req));
				accepted_count++;
			end
			if (!(in_valid && in_stall)) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (pixel_queue.size() != 0) begin
					in_req <= pixel_queue.pop_front();
					in_valid <= 1'b1;
					send_gap = pick_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_chan(string name, logic [CHAN_BITS-1:0] want,
		logic [CHAN_BITS-1:0] got);
		if (got !== want) begin
			fail_count++;
			if (fail_count <= MAX_REPORTS)
				$error("%s: expected %0d, got %0d", name, want, got);
		end
	endtask

	// Result monitor plus random output stall
	always @(posedge clk) begin : color_monitor
		int stall_left;
		color_req_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_colors.size() == 0) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS)
						$error("color %h with no request outstanding", out_req);
				end else begin
					want = expected_colors.pop_front();
					check_chan("out_red", want.out_red, out_req.out_red);
					check_chan("out_green", want.out_green, out_req.out_green);
					check_chan("out_blue", want.out_blue, out_req.out_blue);
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else begin
				stall_left = pick_gap();
				out_stall <= 1'b0;
			end
		end
	end

	// Register write; the copy is updated at the edge that takes the write.
	// Indexes past the last register must leave everything alone.
	task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
		@(posedge clk);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_wen <= 1'b0;
		case (idx)
			REG_START_COLOR: start_color_reg = data[COLOR_BITS-1:0];
			REG_END_COLOR:   end_color_reg = data[COLOR_BITS-1:0];
			REG_FADE_RADIUS: fade_radius_reg = data[RADIUS_BITS-1:0];
			REG_CENTER_X:    center_x_reg = data[COORD_BITS-1:0];
			REG_CENTER_Y:    center_y_reg = data[COORD_BITS-1:0];
			default: ;
		endcase
	endtask

	task automatic push_pixel(int x, int y);
		pix_req_t p;
		p.pixel_x = COORD_BITS'(x);
		p.pixel_y = COORD_BITS'(y);
		pixel_queue.push_back(p);
		pushed_count++;
	endtask

	// Wait until every request is in and every color is out, then let the
	// pipeline settle before any register write
	task automatic drain();
		while (pushed_count != accepted_count || expected_colors.size() != 0)
			@(posedge clk);
		repeat (PIPE_LATENCY + 4) @(posedge clk);
	endtask

	function automatic logic [COLOR_BITS-1:0] random_color();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll == 0)
			return '0;
		if (roll == 1)
			return '1;
		return COLOR_BITS'($urandom());
	endfunction

	function automatic logic [COORD_BITS-1:0] random_center();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll == 0)
			return '0;
		if (roll == 1)
			return '1;
		return COORD_BITS'($urandom());
	endfunction

	// New settings for a random phase; upper data bits carry junk the block must drop
	task automatic random_config();
		logic [CFG_DATA_BITS-1:0] data;
		int roll;
		write_reg(REG_START_COLOR, random_color());
		write_reg(REG_END_COLOR, random_color());
		roll = $urandom_range(0, 9);
		data = CFG_DATA_BITS'($urandom());
		if (roll == 0)
			data[RADIUS_BITS-1:0] = '0;
		else if (roll == 1)
			data[RADIUS_BITS-1:0] = '1;
		else if (roll < 6)
			data[RADIUS_BITS-1:0] = RADIUS_BITS'($urandom_range(1, 64));
		else
			data[RADIUS_BITS-1:0] = RADIUS_BITS'($urandom_range(1, 2**RADIUS_BITS - 1));
		write_reg(REG_FADE_RADIUS, data);
		data = CFG_DATA_BITS'($urandom());
		data[COORD_BITS-1:0] = random_center();
		write_reg(REG_CENTER_X, data);
		data = CFG_DATA_BITS'($urandom());
		data[COORD_BITS-1:0] = random_center();
		write_reg(REG_CENTER_Y, data);
	endtask

	// Most pixels land around the center so the fade is exercised; the window
	// may wrap at the coordinate edge, which the block must treat modulo 2^COORD_BITS
	task automatic push_random_pixel();
		int span;
		if ($urandom_range(0, 9) < 3 || fade_radius_reg == 0) begin
			push_pixel($urandom(), $urandom());
		end else begin
			span = fade_radius_reg / 2 + 1;
			push_pixel(center_x_reg + $urandom_range(0, 2 * span) - span,
				center_y_reg + $urandom_range(0, 2 * span) - span);
		end
	endtask

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// Registers straight out of reset: zero radius, black end color
		push_pixel(0, 0);
		push_pixel(4095, 4095);
		push_pixel(0, 4095);
		drain();

		// Widest fade from white to black: every distance is inside the radius
		write_reg(REG_START_COLOR, 24'hFFFFFF);
		write_reg(REG_END_COLOR, 24'h000000);
		write_reg(REG_FADE_RADIUS, 24'h001FFF);
		write_reg(REG_CENTER_X, 24'h000000);
		write_reg(REG_CENTER_Y, 24'h000000);
		push_pixel(0, 0);
		push_pixel(4095, 4095);
		push_pixel(1, 0);
		push_pixel(4095, 0);
		push_pixel(2048, 2048);
		drain();

		// Radius of one at the far corner: only the center itself fades
		write_reg(REG_START_COLOR, 24'h000000);
		write_reg(REG_END_COLOR, 24'hFFFFFF);
		write_reg(REG_FADE_RADIUS, 24'hFFE001);
		write_reg(REG_CENTER_X, 24'hABCFFF);
		write_reg(REG_CENTER_Y, 24'h000FFF);
		push_pixel(4095, 4095);
		push_pixel(4094, 4095);
		push_pixel(0, 0);
		drain();

		// Mixed colors; distances just inside, on and just past the radius.
		// Writes to unmapped indexes go in before the pixels and must change nothing.
		write_reg(REG_START_COLOR, 24'hA53CF0);
		write_reg(REG_END_COLOR, 24'h5AC30F);
		write_reg(REG_FADE_RADIUS, 24'h000064);
		write_reg(REG_CENTER_X, 24'h0007D0);
		write_reg(REG_CENTER_Y, 24'h0003E8);
		for (int idx = REG_CENTER_Y + 1; idx < 2**CFG_IDX_BITS; idx++)
			write_reg(CFG_IDX_BITS'(idx), '1);
		push_pixel(2099, 1000);
		push_pixel(1950, 1050);
		push_pixel(1901, 1000);
		push_pixel(2000, 1101);
		push_pixel(2000, 1000);
		push_pixel(2050, 950);
		drain();

		// Random phases; some run with no gaps and no stalls at all.
		// Each phase ends with the sender held back until every color is home.
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			random_config();
			no_idle = (phase % 3 == 2);
			repeat (PIXELS_PER_PHASE) push_random_pixel();
			drain();
		end
		no_idle = 1'b0;

		// Extra settle so a stray late color is still caught
		repeat (2 * PIPE_LATENCY) @(posedge clk);
		if (fail_count == 0 && expected_colors.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
